// ===== rtl/text_console_writer_with_scroll_core_macros.svh =====
// Assertion macros shared by the console core modules.
`ifndef TEXT_CONSOLE_WRITER_WITH_SCROLL_CORE_MACROS_SVH
`define TEXT_CONSOLE_WRITER_WITH_SCROLL_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define TCW_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define TCW_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/tcw_pkg.sv =====
// Types and constants shared by the console core modules.
package tcw_pkg;

	localparam logic       OP_WRITE         = 1'b0;
	localparam logic       OP_READ          = 1'b1;
	localparam logic [7:0] NEWLINE_CODE     = 8'd10;
	localparam logic [15:0] BLANK_CELL      = 16'h0720;
	localparam logic [7:0] TEXT_COLOR_RESET = 8'h07;

	typedef struct packed {
		logic       op;
		logic [7:0] char_code;
		logic [6:0] read_col;
		logic [4:0] read_row;
	} item_t;

	typedef struct packed {
		logic [15:0] cell_value;
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
	} result_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic clear_wr;
		logic wipe_wr;
		logic finish;
		logic finish_ram;
	} cmd_t;

	typedef struct packed {
		logic rd_mem;
		logic scroll;
		logic clear_last;
		logic wipe_last;
	} status_t;

endpackage

// ===== rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Controller state machine of the console core.
`include "text_console_writer_with_scroll_core_macros.svh"

module tcw_ctrl
	import tcw_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_RDWAIT = 6'b001000,
		ST_WIPE   = 6'b010000,
		ST_RESP   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (st.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				if (st.rd_mem) begin
					state_d = ST_RDWAIT;
				end else if (st.scroll) begin
					state_d = ST_WIPE;
				end else begin
					state_d = ST_RESP;
				end
			end
			ST_RDWAIT: begin
				cmd.finish     = 1'b1;
				cmd.finish_ram = 1'b1;
				state_d        = ST_IDLE;
			end
			ST_WIPE: begin
				cmd.wipe_wr = 1'b1;
				if (st.wipe_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	`TCW_ASSERT_NXT(a_accept_to_exec, (state_q == ST_IDLE) && start, state_q == ST_EXEC, "accepted transaction did not execute")
	`TCW_ASSERT_IMP(a_wipe_entry, state_q == ST_WIPE, ($past(state_q) == ST_EXEC) || ($past(state_q) == ST_WIPE), "row wipe entered without a scroll")

endmodule

// ===== rtl/tcw_dp.sv =====
// Datapath of the console core: cursor, scroll offset, screen RAM and result register.
`include "text_console_writer_with_scroll_core_macros.svh"

module tcw_dp
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	input  cmd_t       cmd,
	output status_t    st,
	output logic       done,
	output result_t    result
);

	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);

	item_t         item_q;
	logic [7:0]    text_color_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [RW-1:0] base_q;
	logic [RW-1:0] wipe_row_q;
	logic [AW-1:0] cnt_q;
	logic          done_q;
	result_t       result_q;

	logic          is_newline;
	logic          col_last;
	logic          row_last;
	logic          in_range;
	logic [CW-1:0] rd_col;
	logic [RW-1:0] rd_row;
	logic [RW-1:0] base_next;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [15:0]   wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [15:0]   rd_data;

	function automatic logic [RW-1:0] to_phys(logic [RW-1:0] r, logic [RW-1:0] b);
		logic [RW:0] s;
		s = {1'b0, r} + {1'b0, b};
		if (s >= (RW+1)'(ROWS)) begin
			s = s - (RW+1)'(ROWS);
		end
		return s[RW-1:0];
	endfunction

	function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
		return AW'(32'(r) * COLUMNS + 32'(c));
	endfunction

	assign is_newline = (item_q.char_code == NEWLINE_CODE);
	assign col_last   = (col_q == CW'(COLUMNS - 1));
	assign row_last   = (row_q == RW'(ROWS - 1));
	assign in_range   = (32'(item_q.read_col) < COLUMNS) && (32'(item_q.read_row) < ROWS);
	assign rd_col     = CW'(item_q.read_col);
	assign rd_row     = RW'(item_q.read_row);
	assign base_next  = (base_q == RW'(ROWS - 1)) ? '0 : base_q + RW'(1);

	assign st.rd_mem     = (item_q.op == OP_READ) && in_range;
	assign st.scroll     = (item_q.op == OP_WRITE) && (is_newline || col_last) && row_last;
	assign st.clear_last = (cnt_q == AW'(DEPTH - 1));
	assign st.wipe_last  = (cnt_q == AW'(COLUMNS - 1));

	always_comb begin
		wr_en = cmd.clear_wr || cmd.wipe_wr ||
			(cmd.exec && (item_q.op == OP_WRITE) && !is_newline);
		priority if (cmd.clear_wr) begin
			wr_addr = cnt_q;
			wr_data = BLANK_CELL;
		end else if (cmd.wipe_wr) begin
			wr_addr = cell_addr(wipe_row_q, CW'(cnt_q));
			wr_data = '0;
		end else begin
			wr_addr = cell_addr(to_phys(row_q, base_q), col_q);
			wr_data = {text_color_q, item_q.char_code};
		end
	end

	assign rd_en   = cmd.exec && st.rd_mem;
	assign rd_addr = cell_addr(to_phys(rd_row, base_q), rd_col);

	tcw_ram #(
		.WIDTH(16),
		.DEPTH(DEPTH)
	) u_screen (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= TEXT_COLOR_RESET;
			col_q        <= '0;
			row_q        <= '0;
			base_q       <= '0;
			wipe_row_q   <= '0;
			cnt_q        <= '0;
			done_q       <= 1'b0;
		end else begin
			if (cfg_we) begin
				text_color_q <= cfg_wdata;
			end
			if (cmd.exec && (item_q.op == OP_WRITE)) begin
				if (is_newline || col_last) begin
					col_q <= '0;
					if (row_last) begin
						base_q     <= base_next;
						wipe_row_q <= base_q;
					end else begin
						row_q <= row_q + RW'(1);
					end
				end else begin
					col_q <= col_q + CW'(1);
				end
			end
			if (cmd.clear_wr || cmd.wipe_wr) begin
				if ((cmd.clear_wr && st.clear_last) || (cmd.wipe_wr && st.wipe_last)) begin
					cnt_q <= '0;
				end else begin
					cnt_q <= cnt_q + AW'(1);
				end
			end
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.finish) begin
			result_q.cell_value <= cmd.finish_ram ? rd_data : '0;
			result_q.cursor_col <= 7'(col_q);
			result_q.cursor_row <= 5'(row_q);
		end
	end

	assign done   = done_q;
	assign result = result_q;

	`TCW_ASSERT_IMP(a_cursor_in_screen, 1'b1, (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS), "cursor left the screen")
	`TCW_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe held for two cycles")
	`TCW_ASSERT_NXT(a_wipe_old_top, cmd.exec && st.scroll, wipe_row_q == $past(base_q), "scroll wipes the wrong row")

endmodule

// ===== rtl/text_console_writer_with_scroll_core.sv =====
// Top level of the text console writer with scrolling.
//
// channel   direction  handshake          payload
// item      in         start & !busy      item_t   (op, char_code, read_col, read_row)
// result    out        done, one cycle    result_t (cell_value, cursor_col, cursor_row)
// config    in         cfg_we             cfg_wdata, the text colour byte
//
// An accepted item runs EXEC, then RDWAIT or RESP, to its result strobe; busy drops with it.
// A scrolling write runs WIPE to zero the new bottom row before RESP; rows rotate by offset.
// After reset busy stays high while the RAM is swept to blank cells.
// Results cannot be stalled; each is shown for exactly one cycle under done.
module text_console_writer_with_scroll_core
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,
	output logic       done,
	output result_t    result
);

	cmd_t    cmd;
	status_t st;

	tcw_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.st    (st),
		.cmd   (cmd)
	);

	tcw_dp #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.st       (st),
		.done     (done),
		.result   (result)
	);

endmodule
